>>> rtl/core/ecint_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecint_pkg
// Types and constants shared by the envelope cubic interpolator modules.
// ----------------------------------------------------------------------------
package ecint_pkg;

    localparam int SAMPLE_FRAC_BITS = 15;
    localparam int TIME_BITS        = 32;
    localparam int SAMPLE_W         = 16;
    localparam int POS_FRAC         = 24;
    localparam int POS_W            = POS_FRAC + 1;
    localparam int FRAC_W           = 25;
    localparam int TAN_W            = SAMPLE_W + 1;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 25;

    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 26;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 56;

    localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(1 << SAMPLE_FRAC_BITS);
    localparam logic [POS_W-1:0]    POS_ONE    = POS_W'(1 << POS_FRAC);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC   = 2'd2;

    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_CUBIC  = 2'd1;
    localparam logic [1:0] CURVE_HOLD   = 2'd2;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 25'd268435;

    localparam logic ACT_FULL   = 1'b0;
    localparam logic ACT_INTERP = 1'b1;

    typedef struct packed {
        logic              enable;
        logic [1:0]        curve_mode;
        logic [FRAC_W-1:0] frac_per_us;
        logic              reseed_arm;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_TPOS,
        ST_LIN,
        ST_SQ,
        ST_CUBE,
        ST_MAC,
        ST_RND,
        ST_FIN
    } st_t;

    typedef enum logic [1:0] {
        PSEL_ZERO,
        PSEL_ONE,
        PSEL_PROD
    } pos_sel_t;

endpackage

>>> rtl/core/ecint_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecint_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ecint_mul
    import ecint_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

>>> rtl/core/ecint_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecint_ctrl
// Sample history, tick position and curve sequencer around one multiplier.
// ----------------------------------------------------------------------------
module ecint_ctrl
    import ecint_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_action,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  logic [TIME_BITS-1:0]  s_tick_start,
    input  logic [TIME_BITS-1:0]  s_now,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_level
);

    localparam logic signed [MUL_P_W-1:0] P_POS_ONE =
        $signed({{(MUL_P_W-POS_W){1'b0}}, POS_ONE});
    localparam logic signed [MUL_A_W-1:0] H_ONE =
        $signed({{(MUL_A_W-POS_W){1'b0}}, POS_ONE});
    localparam logic signed [ACC_W-1:0] LIN_HALF = ACC_W'(1) <<< (POS_FRAC - 1);
    localparam logic signed [ACC_W-1:0] CUB_HALF = ACC_W'(1) <<< POS_FRAC;
    localparam logic signed [MUL_P_W-1:0] SQ_HALF = MUL_P_W'(1) <<< (POS_FRAC - 1);
    localparam logic [2:0] MAC_LAST = 3'd4;

    st_t                        state_reg, state_next;
    logic [SAMPLE_W-1:0]        hist_reg [4];
    logic [SAMPLE_W-1:0]        hist_next [4];
    logic signed [TAN_W-1:0]    tan_reg [2];
    logic signed [TAN_W-1:0]    tan_next [2];
    logic [TIME_BITS-1:0]       ts_reg, ts_next;
    logic [TIME_BITS-1:0]       now_reg, now_next;
    logic [SAMPLE_W-1:0]        last_reg, last_next;
    logic                       reseed_reg, reseed_next;
    pos_sel_t                   tsel_reg, tsel_next;
    logic [POS_W-1:0]           t_reg, t_next;
    logic [POS_W-1:0]           t2_reg, t2_next;
    logic [POS_W-1:0]           t3_reg, t3_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [2:0]                 k_reg, k_next;
    logic [SAMPLE_W-1:0]        res_reg, res_next;
    logic                       out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]        out_data_reg, out_data_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;

    logic [SAMPLE_W-1:0]        samp_sat;
    logic [SAMPLE_W-1:0]        base [4];
    logic [TIME_BITS-1:0]       elapsed;
    logic [POS_W-1:0]           t_comb;
    logic [POS_W-1:0]           rnd_comb;
    logic signed [MUL_P_W-1:0]  rnd_full;
    logic signed [TAN_W-1:0]    p_diff;
    logic signed [MUL_A_W-1:0]  te, t2e, t3e;
    logic signed [MUL_A_W-1:0]  h00, h10, h01, h11;
    logic signed [ACC_W-1:0]    lin_sum, lin_v, cub_v;
    logic                       accept;
    logic                       is_hold, is_lin;

    function automatic logic [SAMPLE_W-1:0] clamp_level(input logic signed [ACC_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v[ACC_W-1])
            r = '0;
        else if (v > $signed({{(ACC_W-SAMPLE_W){1'b0}}, SAMPLE_ONE}))
            r = SAMPLE_ONE;
        else
            r = v[SAMPLE_W-1:0];
        return r;
    endfunction

    ecint_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_level  = out_data_reg;
    assign is_hold  = (cfg.curve_mode == CURVE_HOLD);
    assign is_lin   = (cfg.curve_mode == CURVE_LINEAR);

    // datapath terms
    always_comb
    begin
        samp_sat = (s_sample > SAMPLE_ONE) ? SAMPLE_ONE : s_sample;
        for (int i = 0; i < 4; i++)
            base[i] = reseed_reg ? last_reg : hist_reg[i];
        elapsed = now_reg - ts_reg;

        case (tsel_reg)
            PSEL_ZERO: t_comb = '0;
            PSEL_ONE:  t_comb = POS_ONE;
            default:   t_comb = (prod > P_POS_ONE) ? POS_ONE : prod[POS_W-1:0];
        endcase

        rnd_full = (prod + SQ_HALF) >>> POS_FRAC;
        rnd_comb = rnd_full[POS_W-1:0];

        p_diff = $signed({1'b0, hist_reg[2]}) - $signed({1'b0, hist_reg[1]});

        te  = $signed({{(MUL_A_W-POS_W){1'b0}}, t_reg});
        t2e = $signed({{(MUL_A_W-POS_W){1'b0}}, t2_reg});
        t3e = $signed({{(MUL_A_W-POS_W){1'b0}}, t3_reg});
        h00 = (t3e <<< 1) - (t2e <<< 1) - t2e + H_ONE;
        h10 = t3e - (t2e <<< 1) + te;
        h01 = (t2e <<< 1) + t2e - (t3e <<< 1);
        h11 = t3e - t2e;

        lin_sum = $signed({{(ACC_W-SAMPLE_W){1'b0}}, hist_reg[1]}) <<< POS_FRAC;
        lin_sum = lin_sum + ACC_W'(prod);
        lin_v   = (lin_sum + LIN_HALF) >>> POS_FRAC;
        cub_v   = (acc_reg + CUB_HALF) >>> (POS_FRAC + 1);
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POS:
            begin
                mul_a = $signed({{(MUL_A_W-POS_FRAC){1'b0}}, elapsed[POS_FRAC-1:0]});
                mul_b = $signed({{(MUL_B_W-FRAC_W){1'b0}}, cfg.frac_per_us});
            end
            ST_TPOS:
            begin
                mul_a = $signed({{(MUL_A_W-POS_W){1'b0}}, t_comb});
                if (is_lin)
                    mul_b = {{(MUL_B_W-TAN_W){p_diff[TAN_W-1]}}, p_diff};
                else
                    mul_b = $signed({{(MUL_B_W-POS_W){1'b0}}, t_comb});
            end
            ST_SQ:
            begin
                mul_a = $signed({{(MUL_A_W-POS_W){1'b0}}, rnd_comb});
                mul_b = $signed({{(MUL_B_W-POS_W){1'b0}}, t_reg});
            end
            ST_MAC:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = h00;
                        mul_b = $signed({{(MUL_B_W-SAMPLE_W-1){1'b0}}, hist_reg[1], 1'b0});
                    end
                    3'd1:
                    begin
                        mul_a = h01;
                        mul_b = $signed({{(MUL_B_W-SAMPLE_W-1){1'b0}}, hist_reg[2], 1'b0});
                    end
                    3'd2:
                    begin
                        mul_a = h10;
                        mul_b = {{(MUL_B_W-TAN_W){tan_reg[0][TAN_W-1]}}, tan_reg[0]};
                    end
                    3'd3:
                    begin
                        mul_a = h11;
                        mul_b = {{(MUL_B_W-TAN_W){tan_reg[1][TAN_W-1]}}, tan_reg[1]};
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        hist_next      = hist_reg;
        tan_next       = tan_reg;
        ts_next        = ts_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        reseed_next    = reseed_reg;
        tsel_next      = tsel_reg;
        t_next         = t_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        acc_next       = acc_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_next = s_now;
                    if (s_action == ACT_FULL)
                    begin
                        reseed_next = 1'b0;
                        ts_next     = s_tick_start;
                        last_next   = samp_sat;
                        if (!cfg.enable)
                        begin
                            hist_next = base;
                            if (reseed_reg)
                            begin
                                tan_next[0] = '0;
                                tan_next[1] = '0;
                            end
                            res_next   = samp_sat;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            hist_next[0] = base[1];
                            hist_next[1] = base[2];
                            hist_next[2] = base[3];
                            hist_next[3] = samp_sat;
                            tan_next[0]  = $signed({1'b0, base[3]}) - $signed({1'b0, base[1]});
                            tan_next[1]  = $signed({1'b0, samp_sat}) - $signed({1'b0, base[2]});
                            if (is_hold)
                            begin
                                res_next   = samp_sat;
                                state_next = ST_FIN;
                            end
                            else
                                state_next = ST_POS;
                        end
                    end
                    else if (cfg.enable && !reseed_reg)
                    begin
                        if (is_hold)
                        begin
                            res_next   = last_reg;
                            state_next = ST_FIN;
                        end
                        else
                            state_next = ST_POS;
                    end
                end
            end
            ST_POS:
            begin
                if (elapsed[TIME_BITS-1] || (cfg.frac_per_us == '0))
                    tsel_next = PSEL_ZERO;
                else if (|elapsed[TIME_BITS-2:POS_FRAC])
                    tsel_next = PSEL_ONE;
                else
                    tsel_next = PSEL_PROD;
                state_next = ST_TPOS;
            end
            ST_TPOS:
            begin
                t_next     = t_comb;
                state_next = is_lin ? ST_LIN : ST_SQ;
            end
            ST_LIN:
            begin
                res_next   = clamp_level(lin_v);
                state_next = ST_FIN;
            end
            ST_SQ:
            begin
                t2_next    = rnd_comb;
                state_next = ST_CUBE;
            end
            ST_CUBE:
            begin
                t3_next    = rnd_comb;
                acc_next   = '0;
                k_next     = '0;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (k_reg != 3'd0)
                    acc_next = acc_reg + ACC_W'(prod);
                if (k_reg == MAC_LAST)
                    state_next = ST_RND;
                else
                    k_next = k_reg + 3'd1;
            end
            ST_RND:
            begin
                res_next   = clamp_level(cub_v);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cfg.reseed_arm)
            reseed_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 4; i++)
                hist_reg[i] <= '0;
            tan_reg[0]    <= '0;
            tan_reg[1]    <= '0;
            ts_reg        <= '0;
            now_reg       <= '0;
            last_reg      <= '0;
            reseed_reg    <= 1'b0;
            tsel_reg      <= PSEL_ZERO;
            t_reg         <= '0;
            t2_reg        <= '0;
            t3_reg        <= '0;
            acc_reg       <= '0;
            k_reg         <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            tan_reg       <= tan_next;
            ts_reg        <= ts_next;
            now_reg       <= now_next;
            last_reg      <= last_next;
            reseed_reg    <= reseed_next;
            tsel_reg      <= tsel_next;
            t_reg         <= t_next;
            t2_reg        <= t2_next;
            t3_reg        <= t3_next;
            acc_reg       <= acc_next;
            k_reg         <= k_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

>>> rtl/core/envelope_cubic_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_cubic_interpolator_top
// Envelope upsampler: linear, Catmull-Rom cubic or hold between samples.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser selects a full tick (new sample) or an interp tick;
// tdata carries sample, tick start time and current time. Output stream m_*
// carries the Q1.15 duty level. Config writes go through cfg_we/cfg_addr/
// cfg_wdata; the user must make them only while the block is idle, since
// the block does not check this. One request is worked on at a time;
// s_tready is high only when idle. m_tvalid rises on the same edge that
// returns s_tready, after these steps through the single shared multiplier:
//   disabled, hold mode, or plain sample passthrough:  none
//   linear curve:  t, one product
//   cubic curve:   t, t^2, t^3, four MAC terms
// Interp ticks while disabled or with a reseed pending give no result and
// leave s_tready high. The result sits in an output register; if the
// receiver stalls, the sequencer waits at its last step until the register
// frees, then takes the next request.
// Reset clears history, tangents, times and the pending reseed, and loads
// enable 0, curve cubic and the default reciprocal period.
// ----------------------------------------------------------------------------
module envelope_cubic_interpolator_top
    import ecint_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,   // sample[15:0], tick_time[47:16], now_us[79:48]
    input  logic [0:0]            s_tuser,   // action[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // level[15:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic              enable_reg, enable_next;
    logic [1:0]        curve_reg, curve_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              arm;
    cfg_t              cfg;

    always_comb
    begin
        enable_next = enable_reg;
        curve_next  = curve_reg;
        frac_next   = frac_reg;
        arm         = 1'b0;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ENABLE:
                begin
                    enable_next = cfg_wdata[0];
                    arm         = cfg_wdata[0] && !enable_reg;
                end
                CFG_CURVE:
                    curve_next = cfg_wdata[1:0];
                CFG_FRAC:
                    frac_next = cfg_wdata[FRAC_W-1:0];
                default:
                    arm = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            curve_reg  <= CURVE_CUBIC;
            frac_reg   <= FRAC_RESET;
        end
        else
        begin
            enable_reg <= enable_next;
            curve_reg  <= curve_next;
            frac_reg   <= frac_next;
        end
    end

    assign cfg.enable      = enable_reg;
    assign cfg.curve_mode  = curve_reg;
    assign cfg.frac_per_us = frac_reg;
    assign cfg.reseed_arm  = arm;

    ecint_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_action     (s_tuser[0]),
        .s_sample     (s_tdata[15:0]),
        .s_tick_start (s_tdata[47:16]),
        .s_now        (s_tdata[79:48]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_level      (m_tdata)
    );

endmodule

>>> test/envelope_cubic_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// envelope_cubic_interpolator_top_tb
// Self-checking bench for the envelope interpolator. A bit-exact predictor
// tracks history, tangents, tick time and registers from every accepted
// request and register write. It queues the expected duty levels, and each
// level leaving m_* is compared against the oldest one. Directed requests
// cover passthrough, reseed, the curve modes and the position corners.
// Random traffic then runs under changing idle and backpressure mixes.
// ----------------------------------------------------------------------------
module envelope_cubic_interpolator_top_tb
    import ecint_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [1:0] CURVE_SPARE = 2'd3;
    localparam longint Q24_ONE     = longint'(1) << 24;
    localparam int     SETTLE_CYC  = 16;
    localparam int     STUCK_LIMIT = 5000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata   = '0;   // sample[15:0], tick_time[47:16], now_us[79:48]
    logic [0:0]            s_tuser   = '0;   // action[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // level[15:0]
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    logic              m_en;
    logic [1:0]        m_mode;
    logic [FRAC_W-1:0] m_frac;
    longint            m_hist [4];
    longint            m_tan  [2];
    logic [31:0]       m_tstart;
    longint            m_last;
    logic              m_reseed;

    logic [15:0] pending_levels [$];
    logic [15:0] want_level;
    logic [15:0] new_level;
    bit          has_level;
    int          fail_cnt    = 0;
    int          stuck_cnt   = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;

    envelope_cubic_interpolator_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic longint rnd_shift(input longint x, input int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint tick_pos(input logic [31:0] now);
        logic [31:0] d;
        longint      p;
        d = now - m_tstart;
        if (d[31] || m_frac == '0)
            return 0;
        if (d >= 32'h0100_0000)
            return Q24_ONE;
        p = longint'({32'd0, d}) * longint'({39'd0, m_frac});
        return (p > Q24_ONE) ? Q24_ONE : p;
    endfunction

    function automatic longint curve_level(input logic [31:0] now);
        longint t, t2, t3, p1, p2, v, acc;
        longint h00, h10, h01, h11;
        if (m_mode == CURVE_HOLD)
            return m_last;
        t  = tick_pos(now);
        p1 = m_hist[1];
        p2 = m_hist[2];
        if (m_mode == CURVE_LINEAR)
        begin
            v = rnd_shift(p1 * Q24_ONE + t * (p2 - p1), 24);
        end
        else
        begin
            t2  = rnd_shift(t * t, 24);
            t3  = rnd_shift(t2 * t, 24);
            h00 = 2 * t3 - 3 * t2 + Q24_ONE;
            h10 = t3 - 2 * t2 + t;
            h01 = -2 * t3 + 3 * t2;
            h11 = t3 - t2;
            acc = 2 * (h00 * p1 + h01 * p2) + h10 * m_tan[0] + h11 * m_tan[1];
            v   = rnd_shift(acc, 25);
        end
        if (v < 0)
            v = 0;
        if (v > longint'(SAMPLE_ONE))
            v = longint'(SAMPLE_ONE);
        return v;
    endfunction

    function automatic void reset_envelope();
        m_en     = 1'b0;
        m_mode   = CURVE_CUBIC;
        m_frac   = FRAC_RESET;
        for (int i = 0; i < 4; i++)
            m_hist[i] = 0;
        m_tan[0] = 0;
        m_tan[1] = 0;
        m_tstart = '0;
        m_last   = 0;
        m_reseed = 1'b0;
        pending_levels.delete();
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_ENABLE:
            begin
                if (val[0] != m_en)
                begin
                    if (val[0])
                        m_reseed = 1'b1;
                    m_en = val[0];
                end
            end
            CFG_CURVE: m_mode = val[1:0];
            CFG_FRAC:  m_frac = val[FRAC_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void step_envelope(input logic act, input logic [15:0] smp,
                                          input logic [31:0] ts, input logic [31:0] now,
                                          output bit emit, output logic [15:0] lvl);
        longint s;
        emit = 1'b0;
        lvl  = '0;
        if (act == ACT_FULL)
        begin
            s    = (smp > SAMPLE_ONE) ? longint'(SAMPLE_ONE) : longint'({48'd0, smp});
            emit = 1'b1;
            if (m_reseed)
            begin
                for (int i = 0; i < 4; i++)
                    m_hist[i] = m_last;
                m_tan[0] = 0;
                m_tan[1] = 0;
                m_reseed = 1'b0;
            end
            m_tstart = ts;
            if (!m_en)
            begin
                m_last = s;
                lvl    = 16'(s);
            end
            else
            begin
                m_hist[0] = m_hist[1];
                m_hist[1] = m_hist[2];
                m_hist[2] = m_hist[3];
                m_hist[3] = s;
                m_tan[0]  = m_hist[2] - m_hist[0];
                m_tan[1]  = m_hist[3] - m_hist[1];
                if (m_mode == CURVE_HOLD)
                    lvl = 16'(s);
                else
                    lvl = 16'(curve_level(now));
                m_last = s;
            end
        end
        else if (m_en && !m_reseed)
        begin
            emit = 1'b1;
            lvl  = 16'(curve_level(now));
        end
    endfunction

    // result check, predictor update and stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reset_envelope();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_levels.size() == 0)
                begin
                    $display("%0t: level expected none actual %0d", $time, m_tdata);
                    fail_cnt++;
                end
                else
                begin
                    want_level = pending_levels.pop_front();
                    if (m_tdata !== want_level)
                    begin
                        $display("%0t: level expected %0d actual %0d",
                                 $time, want_level, m_tdata);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_we)
                apply_reg(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
            begin
                step_envelope(s_tuser[0], s_tdata[15:0], s_tdata[47:16], s_tdata[79:48],
                              has_level, new_level);
                if (has_level)
                    pending_levels.push_back(new_level);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
                stuck_cnt = 0;
            else
                stuck_cnt++;
            if (stuck_cnt >= STUCK_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_request(input logic act, input logic [15:0] smp,
                                input logic [31:0] ts, input logic [31:0] now);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {now, ts, smp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop requests, wait for every expected level, then let the core go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        if ($urandom_range(9) == 0)
            return 16'($urandom());
        return 16'($urandom_range(32768));
    endfunction

    task automatic test_disabled_passthrough();
        send_request(ACT_FULL, 16'd0, 32'd0, 32'd0);
        send_request(ACT_FULL, 16'd32768, 32'd5, 32'd6);
        send_request(ACT_FULL, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_INTERP, 16'd100, 32'd0, 32'd10);
        send_request(ACT_FULL, 16'd16384, 32'd10, 32'd10);
    endtask

    task automatic test_enable_reseed();
        settle();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'd20);
        send_request(ACT_FULL, 16'd32768, 32'd1000, 32'd1000);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'd1031);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'd1070);
        settle();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        write_reg(CFG_ENABLE, CFG_DATA_W'(0));
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'd1100);
        send_request(ACT_FULL, 16'd0, 32'd2000, 32'd2010);
        send_request(ACT_FULL, 16'd8192, 32'd2063, 32'd2063);
    endtask

    task automatic test_curve_modes();
        settle();
        write_reg(CFG_CURVE, CFG_DATA_W'(CURVE_LINEAR));
        send_request(ACT_FULL, 16'd24000, 32'd3000, 32'd3000);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'd3020);
        settle();
        write_reg(CFG_CURVE, CFG_DATA_W'(CURVE_HOLD));
        send_request(ACT_FULL, 16'd4000, 32'd3063, 32'd3063);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'd3080);
        settle();
        write_reg(CFG_CURVE, CFG_DATA_W'(CURVE_SPARE));
        send_request(ACT_FULL, 16'd30000, 32'd3126, 32'd3130);
    endtask

    task automatic test_position_edges();
        settle();
        write_reg(CFG_CURVE, CFG_DATA_W'(CURVE_CUBIC));
        send_request(ACT_FULL, 16'd12000, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'h0000_0010);   // wraps past zero
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'hFFFF_FF00);   // before tick start
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'h7FFF_FFEF);   // largest positive elapsed
        settle();
        write_reg(CFG_FRAC, CFG_DATA_W'(0));
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'h0000_000A);
        settle();
        write_reg(CFG_FRAC, 25'h100_0000);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'hFFFF_FFF1);
        settle();
        write_reg(CFG_FRAC, CFG_DATA_W'(1));
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'h00FF_FFEF);
        settle();
        write_reg(CFG_FRAC, 25'h1FF_FFFF);
        write_reg(CFG_UNUSED, 25'h1FF_FFFF);
        send_request(ACT_INTERP, 16'd0, 32'd0, 32'hFFFF_FFF2);
    endtask

    task automatic randomize_regs();
        if ($urandom_range(3) == 0)
            write_reg(CFG_ENABLE, CFG_DATA_W'(0));
        write_reg(CFG_ENABLE, CFG_DATA_W'($urandom_range(7) != 0));
        write_reg(CFG_CURVE, CFG_DATA_W'($urandom_range(3)));
        case ($urandom_range(9))
            0:       write_reg(CFG_FRAC, CFG_DATA_W'(0));
            1:       write_reg(CFG_FRAC, CFG_DATA_W'(1));
            2:       write_reg(CFG_FRAC, 25'h100_0000);
            3:       write_reg(CFG_FRAC, 25'h1FF_FFFF);
            4:       write_reg(CFG_FRAC, CFG_DATA_W'($urandom()));
            default: write_reg(CFG_FRAC, CFG_DATA_W'(32'h100_0000 / $urandom_range(2, 400)));
        endcase
    endtask

    // mostly ordered ticks: full ticks at least one period apart, interp ticks from the last full tick on
    task automatic run_traffic(input int count);
        int          pick;
        int          period;
        logic [31:0] base;
        logic [31:0] ts_last;
        period = (m_frac == '0) ? 200 : int'(32'h100_0000 / {7'd0, m_frac});
        if (period < 2)
            period = 2;
        if (period > 5000)
            period = 5000;
        base    = $urandom();
        ts_last = base;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 22)
            begin
                base    = base + period + $urandom_range(0, 3);
                ts_last = base;
                send_request(ACT_FULL, rand_sample(), base, base + $urandom_range(0, 2));
            end
            else if (pick < 88)
            begin
                send_request(ACT_INTERP, rand_sample(), $urandom(),
                             ts_last + $urandom_range(0, period + period / 4 + 1));
            end
            else
            begin
                send_request(1'($urandom_range(1)), 16'($urandom()), $urandom(), $urandom());
            end
        end
    endtask

    task automatic test_random_traffic(input int idle, input int stall, input int total);
        int done_cnt;
        int burst;
        idle_pct  = idle;
        stall_pct = stall;
        done_cnt  = 0;
        while (done_cnt < total)
        begin
            settle();
            randomize_regs();
            burst = $urandom_range(20, 60);
            if (burst > total - done_cnt)
                burst = total - done_cnt;
            run_traffic(burst / 2);
            settle();
            run_traffic(burst - burst / 2);
            done_cnt += burst;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_disabled_passthrough();
        test_enable_reseed();
        test_curve_modes();
        test_position_edges();
        test_random_traffic(0, 0, 215);
        test_random_traffic(87, 0, 215);
        test_random_traffic(0, 87, 215);
        test_random_traffic(18, 18, 215);
        idle_pct  = 0;
        stall_pct = 0;
        settle();
        if (pending_levels.size() != 0)
            fail_cnt++;
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
